FILE: hdl/uv_sphere_vertex_generator_macros.svh
// Assertion helpers shared by the RTL.
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/uvs_pkg.sv
package uvs_pkg;

  localparam int MAX_RINGS   = 1024;
  localparam int MAX_SECTORS = 1024;
  localparam int SINE_LOG2   = 10;
  localparam int SINE_ENTRIES = 1 << SINE_LOG2;

  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;
  localparam int STEP_W  = 17;
  localparam int FRAC_W  = 17;
  localparam int RAD_W   = 16;
  localparam int POS_W   = 17;
  localparam int NORM_W  = 16;
  localparam int VIDX_W  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MAG_W  = 15;             // 0..16384
  localparam int PH_W   = SINE_LOG2 + 2;  // one turn
  localparam int AW     = SINE_LOG2 + 1;  // table address 0..SINE_ENTRIES
  localparam int FPROD_W = IDX_W + STEP_W;
  localparam int PW     = FRAC_W + SINE_LOG2 + 3;
  localparam int PMAG_W = 17;             // rounded product magnitude
  localparam int MUL_W  = 32;

  localparam int FRAC_SHIFT = 16;
  localparam int Q14_SHIFT  = 14;
  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(65536);
  localparam logic [PW-1:0]     PHASE_HALF = PW'(32768);
  localparam logic [MUL_W-1:0]  Q14_HALF   = MUL_W'(8192);
  localparam longint unsigned   ONE_Q14    = 64'd16384;
  localparam longint unsigned   HALF_PI_Q30 = 64'd1686629713;

  localparam logic [COUNT_W-1:0] RING_MAX_C   = COUNT_W'(MAX_RINGS);
  localparam logic [COUNT_W-1:0] SECTOR_MAX_C = COUNT_W'(MAX_SECTORS);
  localparam logic [COUNT_W-1:0] COUNT_MIN_C  = COUNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_COUNT   = 3'd0,
    CFG_SECTOR_COUNT = 3'd1,
    CFG_RING_STEP    = 3'd2,
    CFG_SECTOR_STEP  = 3'd3,
    CFG_RADIUS       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic            neg;
    logic [AW-1:0]   addr;
  } sine_addr_t;

  typedef logic [MAG_W-1:0] sine_rom_t [SINE_ENTRIES+1];

  function automatic logic [MAG_W-1:0] quarter_sine(longint unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned val;
    x = (HALF_PI_Q30 * i) / SINE_ENTRIES;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 6;   sum = sum - term;
    term = ((term * x2) >> 30) / 20;  sum = sum + term;
    term = ((term * x2) >> 30) / 42;  sum = sum - term;
    term = ((term * x2) >> 30) / 72;  sum = sum + term;
    term = ((term * x2) >> 30) / 110; sum = sum - term;
    term = ((term * x2) >> 30) / 156; sum = sum + term;
    term = ((term * x2) >> 30) / 210; sum = sum - term;
    val = (sum * ONE_Q14 + (64'd1 << 29)) >> 30;
    if (val > ONE_Q14) begin
      val = ONE_Q14;
    end
    return val[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      rom[i] = quarter_sine(longint'(i));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] c,
                                                     logic [COUNT_W-1:0] hi);
    if (c < COUNT_MIN_C) begin
      return COUNT_MIN_C;
    end
    return (c > hi) ? hi : c;
  endfunction

  function automatic logic [FRAC_W-1:0] frac_of(logic [IDX_W-1:0] idx,
                                               logic [STEP_W-1:0] step);
    logic [FPROD_W-1:0] f;
    f = FPROD_W'(idx) * FPROD_W'(step);
    return (f > FPROD_W'(FRAC_ONE)) ? FRAC_ONE : f[FRAC_W-1:0];
  endfunction

  // (f * 2^sh + half) >> 16, wrapped to one turn
  function automatic logic [PH_W-1:0] phase_of(logic [FRAC_W-1:0] f, int sh);
    logic [PW-1:0] t;
    t = (PW'(f) << sh) + PHASE_HALF;
    return t[FRAC_SHIFT +: PH_W];
  endfunction

  function automatic sine_addr_t sine_addr(logic [PH_W-1:0] p);
    sine_addr_t      r;
    logic [SINE_LOG2-1:0] o;
    logic [1:0]      q;
    o = p[SINE_LOG2-1:0];
    q = p[PH_W-1 -: 2];
    r.addr = q[0] ? (AW'(SINE_ENTRIES) - AW'(o)) : AW'(o);
    r.neg = q[1];
    return r;
  endfunction

  // |a*b| rounded half up after >> 14
  function automatic logic [PMAG_W-1:0] mul_round14(logic [RAD_W-1:0] a,
                                                   logic [RAD_W-1:0] b);
    logic [MUL_W-1:0] t;
    t = MUL_W'(a) * MUL_W'(b) + Q14_HALF;
    return t[Q14_SHIFT +: PMAG_W];
  endfunction

endpackage

FILE: hdl/uvs_sine_rom.sv
module uvs_sine_rom
  import uvs_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     addr_a,
  input  logic [AW-1:0]     addr_b,
  output logic [MAG_W-1:0]  rd_data_a,
  output logic [MAG_W-1:0]  rd_data_b
);

  logic [MAG_W-1:0] rd_data_a_r;
  logic [MAG_W-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a_r <= SINE_ROM[addr_a];
      rd_data_b_r <= SINE_ROM[addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

FILE: hdl/uv_sphere_vertex_generator.sv
// UV sphere vertex generator.
// Input channel: in_valid / in_stall with in_ring_index and in_sector_index,
// one grid point per word. Result channel: out_valid / out_stall with the
// vertex position, normal, texture coordinates and quad indices of that point.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Registers: 0 ring count, 1 sector count, 2 ring step,
// 3 sector step, 4 radius. Write them only while no word is in flight.
// Path: an accepted word passes the stage 1 to stage 5 registers and is on the
// result ports from stage 5. Throughput: one word per cycle while out_stall
// is low, set by the five-stage pipeline (fractions, phases, quarter-wave
// sine ROM read, normal product, position product); the ROM is held in two
// dual-read copies so all four sine lookups happen in the same stage.
// Reset: the pipeline empties and the registers return to 2 rings, 2 sectors,
// steps of 1.0 and radius 256.
// Stall: a stalled result holds; stages behind it keep filling bubbles, and
// in_stall rises only when every stage holds a word.
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [IDX_W-1:0]          in_ring_index,
  input  logic [IDX_W-1:0]          in_sector_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [POS_W-1:0]   out_pos_x,
  output logic signed [POS_W-1:0]   out_pos_y,
  output logic signed [POS_W-1:0]   out_pos_z,
  output logic signed [NORM_W-1:0]  out_norm_x,
  output logic signed [NORM_W-1:0]  out_norm_y,
  output logic signed [NORM_W-1:0]  out_norm_z,
  output logic [FRAC_W-1:0]         out_tex_u,
  output logic [FRAC_W-1:0]         out_tex_v,
  output logic                      out_quad_valid,
  output logic [VIDX_W-1:0]         out_index_a,
  output logic [VIDX_W-1:0]         out_index_b,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  `include "uv_sphere_vertex_generator_macros.svh"

  // configuration
  logic [COUNT_W-1:0] ring_count_r;
  logic [COUNT_W-1:0] sector_count_r;
  logic [STEP_W-1:0]  ring_step_r;
  logic [STEP_W-1:0]  sector_step_r;
  logic [RAD_W-1:0]   radius_r;
  logic [COUNT_W-1:0] rc;
  logic [COUNT_W-1:0] sc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r   <= COUNT_W'(2);
      sector_count_r <= COUNT_W'(2);
      ring_step_r    <= STEP_W'(65536);
      sector_step_r  <= STEP_W'(65536);
      radius_r       <= RAD_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RING_COUNT:   ring_count_r   <= cfg_data[COUNT_W-1:0];
        CFG_SECTOR_COUNT: sector_count_r <= cfg_data[COUNT_W-1:0];
        CFG_RING_STEP:    ring_step_r    <= cfg_data[STEP_W-1:0];
        CFG_SECTOR_STEP:  sector_step_r  <= cfg_data[STEP_W-1:0];
        CFG_RADIUS:       radius_r       <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign rc = clamp_count(ring_count_r, RING_MAX_C);
  assign sc = clamp_count(sector_count_r, SECTOR_MAX_C);

  // pipeline flow control
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  assign adv5 = !v5_r || !out_stall;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // stage 1: fractions, row base, quad flag
  logic [FRAC_W-1:0]  s1_u_r, s1_v_r;
  logic [VIDX_W-1:0]  s1_row_r;
  logic [IDX_W-1:0]   s1_sector_r;
  logic               s1_qv_r;
  logic               qv_nxt;

  assign qv_nxt = ((COUNT_W'(in_ring_index) + COUNT_W'(1)) < rc) &&
                  ((COUNT_W'(in_sector_index) + COUNT_W'(1)) < sc);

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_v_r      <= frac_of(in_ring_index, ring_step_r);
      s1_u_r      <= frac_of(in_sector_index, sector_step_r);
      s1_row_r    <= VIDX_W'(VIDX_W'(in_ring_index) * VIDX_W'(sc));
      s1_sector_r <= in_sector_index;
      s1_qv_r     <= qv_nxt;
    end
  end

  // stage 2: phases to table addresses, vertex indices
  logic [PH_W-1:0]    pol_ph, az_ph;
  sine_addr_t         s2_sin_pol_r, s2_cos_pol_r, s2_sin_az_r, s2_cos_az_r;
  logic [FRAC_W-1:0]  s2_u_r, s2_v_r;
  logic [VIDX_W-1:0]  s2_idx_a_r, s2_idx_b_r;
  logic [VIDX_W-1:0]  idx_a_nxt;
  logic               s2_qv_r;

  assign pol_ph = phase_of(s1_v_r, SINE_LOG2 + 1);
  assign az_ph  = phase_of(s1_u_r, SINE_LOG2 + 2);
  assign idx_a_nxt = s1_row_r + VIDX_W'(s1_sector_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_sin_pol_r <= sine_addr(pol_ph);
      s2_cos_pol_r <= sine_addr(pol_ph + PH_W'(SINE_ENTRIES));
      s2_sin_az_r  <= sine_addr(az_ph);
      s2_cos_az_r  <= sine_addr(az_ph + PH_W'(SINE_ENTRIES));
      s2_u_r       <= s1_u_r;
      s2_v_r       <= s1_v_r;
      s2_idx_a_r   <= idx_a_nxt;
      s2_idx_b_r   <= idx_a_nxt + VIDX_W'(sc);
      s2_qv_r      <= s1_qv_r;
    end
  end

  // stage 3: sine ROM reads
  logic [MAG_W-1:0]   sin_pol_mag, cos_pol_mag, sin_az_mag, cos_az_mag;
  logic               s3_sin_pol_neg_r, s3_cos_pol_neg_r;
  logic               s3_sin_az_neg_r, s3_cos_az_neg_r;
  logic [FRAC_W-1:0]  s3_u_r, s3_v_r;
  logic [VIDX_W-1:0]  s3_idx_a_r, s3_idx_b_r;
  logic               s3_qv_r;

  uvs_sine_rom u_rom_pol (
    .clk       (clk),
    .rd_en     (adv3),
    .addr_a    (s2_sin_pol_r.addr),
    .addr_b    (s2_cos_pol_r.addr),
    .rd_data_a (sin_pol_mag),
    .rd_data_b (cos_pol_mag)
  );

  uvs_sine_rom u_rom_az (
    .clk       (clk),
    .rd_en     (adv3),
    .addr_a    (s2_sin_az_r.addr),
    .addr_b    (s2_cos_az_r.addr),
    .rd_data_a (sin_az_mag),
    .rd_data_b (cos_az_mag)
  );

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_sin_pol_neg_r <= s2_sin_pol_r.neg;
      s3_cos_pol_neg_r <= s2_cos_pol_r.neg;
      s3_sin_az_neg_r  <= s2_sin_az_r.neg;
      s3_cos_az_neg_r  <= s2_cos_az_r.neg;
      s3_u_r           <= s2_u_r;
      s3_v_r           <= s2_v_r;
      s3_idx_a_r       <= s2_idx_a_r;
      s3_idx_b_r       <= s2_idx_b_r;
      s3_qv_r          <= s2_qv_r;
    end
  end

  // stage 4: normal, sign-magnitude
  logic [MAG_W-1:0]   s4_nx_mag_r, s4_ny_mag_r, s4_nz_mag_r;
  logic               s4_nx_neg_r, s4_ny_neg_r, s4_nz_neg_r;
  logic [PMAG_W-1:0]  nx_prod, nz_prod;
  logic [FRAC_W-1:0]  s4_u_r, s4_v_r;
  logic [VIDX_W-1:0]  s4_idx_a_r, s4_idx_b_r;
  logic               s4_qv_r;

  assign nx_prod = mul_round14(RAD_W'(cos_az_mag), RAD_W'(sin_pol_mag));
  assign nz_prod = mul_round14(RAD_W'(sin_az_mag), RAD_W'(sin_pol_mag));

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_nx_mag_r <= nx_prod[MAG_W-1:0];
      s4_nx_neg_r <= s3_cos_az_neg_r ^ s3_sin_pol_neg_r;
      s4_ny_mag_r <= cos_pol_mag;
      s4_ny_neg_r <= !s3_cos_pol_neg_r;
      s4_nz_mag_r <= nz_prod[MAG_W-1:0];
      s4_nz_neg_r <= s3_sin_az_neg_r ^ s3_sin_pol_neg_r;
      s4_u_r      <= s3_u_r;
      s4_v_r      <= s3_v_r;
      s4_idx_a_r  <= s3_idx_a_r;
      s4_idx_b_r  <= s3_idx_b_r;
      s4_qv_r     <= s3_qv_r;
    end
  end

  // stage 5: position, two's complement, output register
  logic [PMAG_W-1:0]  px_mag, py_mag, pz_mag;
  logic [POS_W-1:0]   pos_x_r, pos_y_r, pos_z_r;
  logic [NORM_W-1:0]  norm_x_r, norm_y_r, norm_z_r;
  logic [FRAC_W-1:0]  tex_u_r, tex_v_r;
  logic [VIDX_W-1:0]  index_a_r, index_b_r;
  logic               quad_valid_r;

  assign px_mag = mul_round14(RAD_W'(s4_nx_mag_r), radius_r);
  assign py_mag = mul_round14(RAD_W'(s4_ny_mag_r), radius_r);
  assign pz_mag = mul_round14(RAD_W'(s4_nz_mag_r), radius_r);

  always_ff @(posedge clk) begin
    if (adv5) begin
      pos_x_r      <= s4_nx_neg_r ? -POS_W'(px_mag) : POS_W'(px_mag);
      pos_y_r      <= s4_ny_neg_r ? -POS_W'(py_mag) : POS_W'(py_mag);
      pos_z_r      <= s4_nz_neg_r ? -POS_W'(pz_mag) : POS_W'(pz_mag);
      norm_x_r     <= s4_nx_neg_r ? -NORM_W'(s4_nx_mag_r) : NORM_W'(s4_nx_mag_r);
      norm_y_r     <= s4_ny_neg_r ? -NORM_W'(s4_ny_mag_r) : NORM_W'(s4_ny_mag_r);
      norm_z_r     <= s4_nz_neg_r ? -NORM_W'(s4_nz_mag_r) : NORM_W'(s4_nz_mag_r);
      tex_u_r      <= s4_u_r;
      tex_v_r      <= s4_v_r;
      index_a_r    <= s4_idx_a_r;
      index_b_r    <= s4_idx_b_r;
      quad_valid_r <= s4_qv_r;
    end
  end

  assign out_valid      = v5_r;
  assign out_pos_x      = pos_x_r;
  assign out_pos_y      = pos_y_r;
  assign out_pos_z      = pos_z_r;
  assign out_norm_x     = norm_x_r;
  assign out_norm_y     = norm_y_r;
  assign out_norm_z     = norm_z_r;
  assign out_tex_u      = tex_u_r;
  assign out_tex_v      = tex_v_r;
  assign out_quad_valid = quad_valid_r;
  assign out_index_a    = index_a_r;
  assign out_index_b    = index_b_r;

  `UVS_ASSERT_NOW(a_stall_only_full, in_stall,
                  v1_r && v2_r && v3_r && v4_r && v5_r,
                  "input stalled with a bubble in the pipeline")
  `UVS_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v1_r,
                   "accepted word did not enter stage 1")
  `UVS_ASSERT_NEXT(a_drain_empty, v5_r && !out_stall && !v4_r, !v5_r,
                   "result repeated after delivery")
  `UVS_ASSERT_NOW(a_norm_range, v5_r,
                  ($signed(norm_x_r) >= -16'sd16384) && ($signed(norm_x_r) <= 16'sd16384),
                  "normal x out of unit range")

endmodule

FILE: sim/uv_sphere_vertex_check.sv
module uv_sphere_vertex_check
  import uvs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [IDX_W-1:0]         in_ring_index,
  input  logic [IDX_W-1:0]         in_sector_index,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [POS_W-1:0]  out_pos_x,
  input  logic signed [POS_W-1:0]  out_pos_y,
  input  logic signed [POS_W-1:0]  out_pos_z,
  input  logic signed [NORM_W-1:0] out_norm_x,
  input  logic signed [NORM_W-1:0] out_norm_y,
  input  logic signed [NORM_W-1:0] out_norm_z,
  input  logic [FRAC_W-1:0]        out_tex_u,
  input  logic [FRAC_W-1:0]        out_tex_v,
  input  logic                     out_quad_valid,
  input  logic [VIDX_W-1:0]        out_index_a,
  input  logic [VIDX_W-1:0]        out_index_b,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       mismatch_count,
  output int                       words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [FRAC_W-1:0]        tex_u;
    logic [FRAC_W-1:0]        tex_v;
    logic                     quad_valid;
    logic [VIDX_W-1:0]        index_a;
    logic [VIDX_W-1:0]        index_b;
  } vertex_t;

  vertex_t expected_vertices[$];
  int sine_mag [0:SINE_ENTRIES];

  logic [COUNT_W-1:0] ring_count;
  logic [COUNT_W-1:0] sector_count;
  logic [STEP_W-1:0]  ring_step;
  logic [STEP_W-1:0]  sector_step;
  logic [RAD_W-1:0]   radius;

  // sin over the first quarter turn, Taylor series to x^15 in Q2.30
  function automatic int quarter_wave(int i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned val;
    x = (QUARTER_TURN_Q30 * 64'(i)) / 64'(SINE_ENTRIES);
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (int k = 1; k <= 13; k += 2) begin
      term = ((term * x2) >> 30) / 64'((k + 1) * (k + 2));
      if (((k >> 1) & 1) == 0) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    val = (acc * 64'd16384 + (64'd1 << 29)) >> 30;
    return (val > 64'd16384) ? 16384 : int'(val);
  endfunction

  function automatic int sine_at(longint unsigned p);
    int q;
    int o;
    int m;
    p = p % 64'(4 * SINE_ENTRIES);
    q = int'(p / 64'(SINE_ENTRIES));
    o = int'(p % 64'(SINE_ENTRIES));
    m = (q & 1) ? sine_mag[SINE_ENTRIES - o] : sine_mag[o];
    return (q >= 2) ? -m : m;
  endfunction

  // >> 14, rounding half away from zero
  function automatic int round_q14(int a, int b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned m;
    logic neg;
    neg = (a < 0) != (b < 0);
    ma = 64'((a < 0) ? -a : a);
    mb = 64'((b < 0) ? -b : b);
    m = (ma * mb + 64'd8192) >> 14;
    return neg ? -int'(m) : int'(m);
  endfunction

  function automatic longint unsigned step_frac(longint unsigned idx, longint unsigned step);
    longint unsigned f;
    f = idx * step;
    return (f > 64'd65536) ? 64'd65536 : f;
  endfunction

  function automatic longint unsigned clamped(longint unsigned c, longint unsigned hi);
    if (c < 64'd2) begin
      return 64'd2;
    end
    return (c > hi) ? hi : c;
  endfunction

  function automatic vertex_t predict_vertex(logic [IDX_W-1:0] r, logic [IDX_W-1:0] s);
    vertex_t vx;
    longint unsigned rc;
    longint unsigned sc;
    longint unsigned v;
    longint unsigned u;
    longint unsigned pol;
    longint unsigned az;
    longint unsigned ri;
    longint unsigned si;
    int sin_pol;
    int cos_pol;
    int sin_az;
    int cos_az;
    int nx;
    int ny;
    int nz;
    int rad;
    ri = 64'(r);
    si = 64'(s);
    rc = clamped(64'(ring_count), 64'(MAX_RINGS));
    sc = clamped(64'(sector_count), 64'(MAX_SECTORS));
    v = step_frac(ri, 64'(ring_step));
    u = step_frac(si, 64'(sector_step));
    pol = (v * 64'(2 * SINE_ENTRIES) + 64'd32768) >> 16;
    az = (u * 64'(4 * SINE_ENTRIES) + 64'd32768) >> 16;
    sin_pol = sine_at(pol);
    cos_pol = sine_at(pol + 64'(SINE_ENTRIES));
    sin_az = sine_at(az);
    cos_az = sine_at(az + 64'(SINE_ENTRIES));
    nx = round_q14(cos_az, sin_pol);
    ny = -cos_pol;
    nz = round_q14(sin_az, sin_pol);
    rad = int'(radius);
    vx.pos_x = POS_W'(round_q14(nx, rad));
    vx.pos_y = POS_W'(round_q14(ny, rad));
    vx.pos_z = POS_W'(round_q14(nz, rad));
    vx.norm_x = NORM_W'(nx);
    vx.norm_y = NORM_W'(ny);
    vx.norm_z = NORM_W'(nz);
    vx.tex_u = FRAC_W'(u);
    vx.tex_v = FRAC_W'(v);
    vx.quad_valid = (ri + 64'd1 < rc) && (si + 64'd1 < sc);
    vx.index_a = VIDX_W'(ri * sc + si);
    vx.index_b = VIDX_W'((ri + 64'd1) * sc + si);
    return vx;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      sine_mag[i] = quarter_wave(i);
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    int delta;
    delta = 0;
    if (!rst_n) begin
      ring_count <= COUNT_W'(2);
      sector_count <= COUNT_W'(2);
      ring_step <= STEP_W'(65536);
      sector_step <= STEP_W'(65536);
      radius <= RAD_W'(256);
      expected_vertices.delete();
      words_in_flight <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          $display("%0t vertex word with none expected: index_a %0d", $time, out_index_a);
          mismatch_count++;
        end else begin
          want = expected_vertices.pop_front();
          delta = delta - 1;
          check_field("pos_x", 64'(want.pos_x), 64'(out_pos_x));
          check_field("pos_y", 64'(want.pos_y), 64'(out_pos_y));
          check_field("pos_z", 64'(want.pos_z), 64'(out_pos_z));
          check_field("norm_x", 64'(want.norm_x), 64'(out_norm_x));
          check_field("norm_y", 64'(want.norm_y), 64'(out_norm_y));
          check_field("norm_z", 64'(want.norm_z), 64'(out_norm_z));
          check_field("tex_u", 64'(want.tex_u), 64'(out_tex_u));
          check_field("tex_v", 64'(want.tex_v), 64'(out_tex_v));
          check_field("quad_valid", 64'(want.quad_valid), 64'(out_quad_valid));
          check_field("index_a", 64'(want.index_a), 64'(out_index_a));
          check_field("index_b", 64'(want.index_b), 64'(out_index_b));
        end
      end
      if (in_valid && !in_stall) begin
        expected_vertices.push_back(predict_vertex(in_ring_index, in_sector_index));
        delta = delta + 1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RING_COUNT:   ring_count <= cfg_data[COUNT_W-1:0];
          CFG_SECTOR_COUNT: sector_count <= cfg_data[COUNT_W-1:0];
          CFG_RING_STEP:    ring_step <= cfg_data[STEP_W-1:0];
          CFG_SECTOR_STEP:  sector_step <= cfg_data[STEP_W-1:0];
          CFG_RADIUS:       radius <= cfg_data[RAD_W-1:0];
          default: ;
        endcase
      end
      words_in_flight <= words_in_flight + delta;
    end
  end

endmodule

FILE: sim/tb_uv_sphere_vertex_generator.sv
module tb_uv_sphere_vertex_generator
  import uvs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 56;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [IDX_W-1:0]         in_ring_index;
  logic [IDX_W-1:0]         in_sector_index;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic signed [POS_W-1:0]  out_pos_z;
  logic signed [NORM_W-1:0] out_norm_x;
  logic signed [NORM_W-1:0] out_norm_y;
  logic signed [NORM_W-1:0] out_norm_z;
  logic [FRAC_W-1:0]        out_tex_u;
  logic [FRAC_W-1:0]        out_tex_v;
  logic                     out_quad_valid;
  logic [VIDX_W-1:0]        out_index_a;
  logic [VIDX_W-1:0]        out_index_b;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  int mismatch_count;
  int words_in_flight;
  int cycles;
  int ring_span;
  int sector_span;
  logic steady;

  uv_sphere_vertex_generator DUT (.*);
  uv_sphere_vertex_check u_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 19);
    end
  end

  function automatic int span_of(int c);
    if (c < 2) begin
      return 2;
    end
    return (c > 1024) ? 1024 : c;
  endfunction

  function automatic int step_for(int c);
    int n;
    n = span_of(c) - 1;
    return (65536 + n / 2) / n;
  endfunction

  task automatic send_point(input int r, input int s);
    if (!steady) begin
      while ($urandom_range(0, 99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_ring_index <= IDX_W'(r);
    in_sector_index <= IDX_W'(s);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic configure(input int rc, input int sc, input int rs, input int ss,
                           input int rad);
    wait_idle();
    write_reg(CFG_RING_COUNT, rc);
    write_reg(CFG_SECTOR_COUNT, sc);
    write_reg(CFG_RING_STEP, rs);
    write_reg(CFG_SECTOR_STEP, ss);
    write_reg(CFG_RADIUS, rad);
    cfg_valid <= 1'b0;
    ring_span = span_of(rc);
    sector_span = span_of(sc);
  endtask

  initial begin
    int rc;
    int sc;
    int pick;
    int gr;
    int gs;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ring_index = '0;
    in_sector_index = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RING_COUNT;
    cfg_data = '0;
    steady = 1'b0;
    ring_span = 2;
    sector_span = 2;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: two rings, two sectors, saturating fractions
    send_point(0, 0);
    send_point(1, 1);
    send_point(1, 0);
    send_point(1023, 1023);

    // 10 x 17 grid: last ring/sector, out of range, full range
    configure(10, 17, 7282, 4096, 65535);
    send_point(0, 0);
    send_point(8, 15);
    send_point(9, 0);
    send_point(0, 16);
    send_point(9, 16);
    send_point(10, 3);
    send_point(3, 17);
    send_point(4, 8);
    send_point(1023, 0);
    send_point(0, 1023);

    // counts below and above range, step extremes, zero radius
    configure(0, 2047, 131071, 0, 0);
    send_point(1023, 1023);
    send_point(0, 0);
    send_point(1, 1023);
    send_point(512, 512);

    // largest grid, index_b wraps past 20 bits
    configure(1024, 1024, 64, 64, 256);
    send_point(1022, 1022);
    send_point(1023, 1023);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(1024, 1024, 64, 64, 65535);
        1: configure(2, 2, 65536, 65536, 1);
        2: configure(1, 0, 131071, 0, 32768);
        default: begin
          rc = $urandom_range(2, 48);
          sc = $urandom_range(2, 48);
          if ($urandom_range(0, 3) == 0) rc = $urandom_range(0, 2047);
          if ($urandom_range(0, 3) == 0) sc = $urandom_range(0, 2047);
          configure(rc, sc, step_for(rc), step_for(sc), $urandom_range(0, 65535));
        end
      endcase
      steady <= (p == 4);
      gr = 0;
      gs = 0;
      repeat (WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_point(gr, gs);
          gs = gs + 1;
          if (gs >= sector_span) begin
            gs = 0;
            gr = (gr + 1) % ring_span;
          end
        end else if (pick < 85) begin
          send_point($urandom_range(0, ring_span - 1), $urandom_range(0, sector_span - 1));
        end else begin
          send_point($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
